@@ sv/dmws_pkg.sv @@
// shared constants and register codes of the damped membrane wave step block
package dmws_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int DISP_BITS_DEF  = 24;

  localparam int IDX_IN_W   = 12;
  localparam int VAL_W      = 24;
  localparam int SAMPLE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int GEOM_W     = 7;
  localparam int COEF_W     = 17;
  localparam int GAIN_W     = 16;

  localparam logic [COEF_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [GEOM_W-1:0] RST_GRID_WIDTH    = 7'd64;
  localparam logic [GEOM_W-1:0] RST_GRID_HEIGHT   = 7'd64;
  localparam logic [COEF_W-1:0] RST_COURANT_COEFF = 17'd16384;
  localparam logic [COEF_W-1:0] RST_DAMP_GAIN     = 17'd65536;
  localparam logic [COEF_W-1:0] RST_DAMP_LOSS     = 17'd65536;
  localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN   = 16'd3840;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_COURANT_COEFF = 3'd2,
    REG_DAMP_GAIN     = 3'd3,
    REG_DAMP_LOSS     = 3'd4,
    REG_OUTPUT_GAIN   = 3'd5
  } cfg_reg_e;

endpackage

@@ sv/dmws_div.sv @@
// restoring divider, one quotient bit per cycle, splits a cell index into row and column
module dmws_div #(
  parameter int NUM_W = dmws_pkg::IDX_IN_W,
  parameter int DEN_W = dmws_pkg::GEOM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      quot_d = '0;
      rem_d  = '0;
      den_d  = den_i;
    end else if (run_q) begin
      num_d  = num_q << 1;
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/damped_membrane_wave_step.sv @@
// top level of the damped membrane wave step: grid memory, cell sweep and pickup
// a load request whose cell index lies outside the grid or on its border is ignored
// throughput: one request at a time, the next is taken once busy falls; set by the
// single read port of the grid memory (five reads per cell) and the cell update chain
// reset: a clearing pass writes zero to every grid word with busy high; the sample
// strobe lasts one cycle and cannot be stalled
module damped_membrane_wave_step #(
  parameter int MAX_WIDTH  = dmws_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dmws_pkg::MAX_HEIGHT_DEF,
  parameter int DISP_BITS  = dmws_pkg::DISP_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode_i,
  input  logic        [dmws_pkg::IDX_IN_W-1:0]   cell_index_i,
  input  logic signed [dmws_pkg::VAL_W-1:0]      cell_value_i,
  output logic signed [dmws_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                   sample_valid_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [dmws_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [dmws_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = 2 ** IDX_W;
  localparam int MW    = 2 * DISP_BITS;
  localparam int GW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int LAP_W = DISP_BITS + 3;
  localparam int P1_W  = LAP_W + 18;
  localparam int P2_W  = DISP_BITS + 18;
  localparam int ACC_W = LAP_W + 19;
  localparam int INN_W = ACC_W - 16;
  localparam int P3_W  = INN_W + 18;
  localparam int SP_W  = DISP_BITS + 17;
  localparam int CW    = dmws_pkg::COEF_W;

  localparam longint DMAX = (64'sd1 <<< (DISP_BITS - 1)) - 64'sd1;
  localparam longint DMIN = -DMAX - 64'sd1;
  localparam longint SMAX = (64'sd1 <<< (dmws_pkg::SAMPLE_W - 1)) - 64'sd1;
  localparam longint SMIN = -SMAX - 64'sd1;

  localparam logic [3:0] PH_U    = 4'd0;
  localparam logic [3:0] PH_N    = 4'd1;
  localparam logic [3:0] PH_S    = 4'd2;
  localparam logic [3:0] PH_W    = 4'd3;
  localparam logic [3:0] PH_E    = 4'd4;
  localparam logic [3:0] PH_LAST = 4'd5;
  localparam logic [3:0] PH_MUL  = 4'd6;
  localparam logic [3:0] PH_ACC  = 4'd7;
  localparam logic [3:0] PH_GAIN = 4'd8;
  localparam logic [3:0] PH_WR   = 4'd9;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_WR    = 8'b0000_1000,
    ST_TICK  = 8'b0001_0000,
    ST_SRD   = 8'b0010_0000,
    ST_SMUL  = 8'b0100_0000,
    ST_SOUT  = 8'b1000_0000
  } state_e;

  function automatic logic [DISP_BITS-1:0] sat_disp(input logic signed [63:0] x);
    if (x > DMAX) return DISP_BITS'(DMAX);
    if (x < DMIN) return DISP_BITS'(DMIN);
    return DISP_BITS'(x);
  endfunction

  function automatic logic [CW-1:0] clamp_q16(input logic [CW-1:0] x);
    return (x > dmws_pkg::Q16_ONE) ? dmws_pkg::Q16_ONE : x;
  endfunction

  // configuration registers
  logic [dmws_pkg::GEOM_W-1:0] cfg_w_q, cfg_h_q;
  logic [CW-1:0]               cfg_rho_q, cfg_g_q, cfg_l_q;
  logic [dmws_pkg::GAIN_W-1:0] cfg_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= dmws_pkg::RST_GRID_WIDTH;
      cfg_h_q    <= dmws_pkg::RST_GRID_HEIGHT;
      cfg_rho_q  <= dmws_pkg::RST_COURANT_COEFF;
      cfg_g_q    <= dmws_pkg::RST_DAMP_GAIN;
      cfg_l_q    <= dmws_pkg::RST_DAMP_LOSS;
      cfg_gain_q <= dmws_pkg::RST_OUTPUT_GAIN;
    end else if (cfg_valid_i) begin
      case (dmws_pkg::cfg_reg_e'(cfg_index_i))
        dmws_pkg::REG_GRID_WIDTH:    cfg_w_q    <= cfg_data_i[dmws_pkg::GEOM_W-1:0];
        dmws_pkg::REG_GRID_HEIGHT:   cfg_h_q    <= cfg_data_i[dmws_pkg::GEOM_W-1:0];
        dmws_pkg::REG_COURANT_COEFF: cfg_rho_q  <= cfg_data_i;
        dmws_pkg::REG_DAMP_GAIN:     cfg_g_q    <= cfg_data_i;
        dmws_pkg::REG_DAMP_LOSS:     cfg_l_q    <= cfg_data_i;
        dmws_pkg::REG_OUTPUT_GAIN:   cfg_gain_q <= cfg_data_i[dmws_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry and coefficients
  logic [GW-1:0]    w_c;
  logic [HW-1:0]    h_c;
  logic [CW-1:0]    rho_c, g_c, l_c;
  logic [GW+HW-1:0] wh;
  logic [IDX_W-1:0] ctr_idx;

  always_comb begin
    if (cfg_w_q < 7'd3) w_c = GW'(3);
    else if (int'(cfg_w_q) > MAX_WIDTH) w_c = GW'(MAX_WIDTH);
    else w_c = GW'(cfg_w_q);
    if (cfg_h_q < 7'd3) h_c = HW'(3);
    else if (int'(cfg_h_q) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
    else h_c = HW'(cfg_h_q);
  end

  assign rho_c   = clamp_q16(cfg_rho_q);
  assign g_c     = clamp_q16(cfg_g_q);
  assign l_c     = clamp_q16(cfg_l_q);
  assign wh      = (GW+HW)'(w_c) * (GW+HW)'(h_c);
  assign ctr_idx = IDX_W'(h_c >> 1) * IDX_W'(w_c) + IDX_W'(w_c >> 1);

  // grid memory, one word per cell holding {current, previous}
  logic [MW-1:0]    mem_q [DEPTH];
  logic [MW-1:0]    rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  logic signed [DISP_BITS-1:0] rd_cur, rd_prev;
  assign rd_cur  = rdata_q[MW-1:DISP_BITS];
  assign rd_prev = rdata_q[DISP_BITS-1:0];

  // control state
  state_e                         state_q, state_d;
  logic [IDX_W-1:0]               clr_q;
  logic [IDX_W-1:0]               idx_q;
  logic [HW-1:0]                  r_q;
  logic [GW-1:0]                  c_q;
  logic [3:0]                     ph_q;
  logic                           sample_valid_q;
  logic [dmws_pkg::IDX_IN_W-1:0]  ld_idx_q;
  logic signed [dmws_pkg::VAL_W-1:0] ld_val_q;

  // cell datapath
  logic signed [DISP_BITS-1:0]       u_q, prev_q;
  logic signed [LAP_W-1:0]           nsum_q;
  logic signed [P1_W-1:0]            p1_q;
  logic signed [P2_W-1:0]            p2_q;
  logic signed [INN_W-1:0]           inner_q;
  logic signed [P3_W-1:0]            p3_q;
  logic signed [SP_W-1:0]            sp_q;
  logic signed [dmws_pkg::SAMPLE_W-1:0] sample_q;

  logic                     accept;
  logic                     div_done;
  logic [dmws_pkg::IDX_IN_W-1:0] div_quot;
  logic [GW-1:0]            div_rem;
  logic                     ld_skip;
  logic                     first_row, last_row, first_col, last_col;
  logic signed [LAP_W-1:0]  lap;
  logic signed [ACC_W-1:0]  acc;
  logic signed [63:0]       inner_r, next_r, sample_r;
  logic [DISP_BITS-1:0]     next_v;
  logic [dmws_pkg::SAMPLE_W-1:0] sample_v;
  logic [DISP_BITS-1:0]     ld_sat;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  dmws_div #(
    .NUM_W(dmws_pkg::IDX_IN_W),
    .DEN_W(GW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && !mode_i),
    .num_i  (cell_index_i),
    .den_i  (w_c),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign ld_skip = (int'(ld_idx_q) >= int'(wh)) || (div_quot == '0) || (div_rem == '0) ||
                   (div_quot == dmws_pkg::IDX_IN_W'(h_c) - dmws_pkg::IDX_IN_W'(1)) ||
                   (div_rem == w_c - GW'(1));

  assign first_row = (r_q == HW'(1));
  assign last_row  = (r_q == h_c - HW'(2));
  assign first_col = (c_q == GW'(1));
  assign last_col  = (c_q == w_c - GW'(2));

  always_comb begin
    lap      = nsum_q - (LAP_W'(u_q) <<< 2);
    acc      = ACC_W'(p1_q) + (ACC_W'(u_q) <<< 17) - ACC_W'(p2_q);
    inner_r  = (64'(acc) + 64'sd32768) >>> 16;
    next_r   = (64'(p3_q) + 64'sd32768) >>> 16;
    next_v   = sat_disp(next_r);
    sample_r = (64'(sp_q) + 64'sd128) >>> 8;
    if (sample_r > SMAX) sample_v = dmws_pkg::SAMPLE_W'(SMAX);
    else if (sample_r < SMIN) sample_v = dmws_pkg::SAMPLE_W'(SMIN);
    else sample_v = dmws_pkg::SAMPLE_W'(sample_r);
    ld_sat   = sat_disp(64'(ld_val_q));
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {next_v, u_q};
    mem_raddr = idx_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(ld_idx_q);
        mem_wdata = {ld_sat, ld_sat};
      end
      ST_TICK: begin
        case (ph_q)
          PH_N:    mem_raddr = idx_q - IDX_W'(w_c);
          PH_S:    mem_raddr = idx_q + IDX_W'(w_c);
          PH_W:    mem_raddr = idx_q - IDX_W'(1);
          PH_E:    mem_raddr = idx_q + IDX_W'(1);
          PH_WR:   mem_we    = 1'b1;
          default: mem_raddr = idx_q;
        endcase
      end
      ST_SRD:  mem_raddr = ctr_idx;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IDX_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = mode_i ? ST_TICK : ST_DIV;
      ST_DIV:   if (div_done) state_d = ld_skip ? ST_IDLE : ST_WR;
      ST_WR:    state_d = ST_IDLE;
      ST_TICK:  if (ph_q == PH_WR && last_col && last_row) state_d = ST_SRD;
      ST_SRD:   state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SOUT;
      ST_SOUT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      idx_q          <= '0;
      r_q            <= '0;
      c_q            <= '0;
      ph_q           <= PH_U;
      sample_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      sample_valid_q <= (state_q == ST_SOUT);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (accept) begin
        idx_q <= IDX_W'(w_c) + IDX_W'(1);
        r_q   <= HW'(1);
        c_q   <= GW'(1);
        ph_q  <= PH_U;
      end else if (state_q == ST_TICK) begin
        if (ph_q == PH_WR) begin
          ph_q <= PH_U;
          if (last_col) begin
            r_q   <= r_q + HW'(1);
            c_q   <= GW'(1);
            idx_q <= idx_q + IDX_W'(3);
          end else begin
            c_q   <= c_q + GW'(1);
            idx_q <= idx_q + IDX_W'(1);
          end
        end else begin
          ph_q <= ph_q + 4'd1;
        end
      end
    end
  end

  // neighbors above and left were already stepped, so their old value sits in the
  // previous slot; neighbors below and right still hold it in the current slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_idx_q <= cell_index_i;
      ld_val_q <= cell_value_i;
    end
    if (state_q == ST_TICK) begin
      case (ph_q)
        PH_N: begin
          u_q    <= rd_cur;
          prev_q <= rd_prev;
        end
        PH_S:    nsum_q <= first_row ? '0 : LAP_W'(rd_prev);
        PH_W:    nsum_q <= last_row  ? nsum_q : nsum_q + LAP_W'(rd_cur);
        PH_E:    nsum_q <= first_col ? nsum_q : nsum_q + LAP_W'(rd_prev);
        PH_LAST: nsum_q <= last_col  ? nsum_q : nsum_q + LAP_W'(rd_cur);
        PH_MUL: begin
          p1_q <= $signed({1'b0, rho_c}) * lap;
          p2_q <= $signed({1'b0, l_c}) * prev_q;
        end
        PH_ACC:  inner_q <= INN_W'(inner_r);
        PH_GAIN: p3_q <= $signed({1'b0, g_c}) * inner_q;
        default: ;
      endcase
    end
    if (state_q == ST_SMUL) begin
      sp_q <= rd_cur * $signed({1'b0, cfg_gain_q});
    end
    if (state_q == ST_SOUT) begin
      sample_q <= sample_v;
    end
  end

  assign sample_o       = sample_q;
  assign sample_valid_o = sample_valid_q;

endmodule
